// ===== rtl/core/arpc_pkg.sv =====
package arpc_pkg;

	// Table size used when the top level is not overridden.
	localparam int unsigned CACHE_ENTRIES_DEFAULT = 32;

	// ARP header checks for IPv4 over Ethernet.
	localparam int unsigned ETH_HEADER_BYTES = 14;
	localparam int unsigned ARP_BODY_BYTES   = 28;
	localparam logic [10:0] MIN_FRAME_BYTES  = 11'(ETH_HEADER_BYTES + ARP_BODY_BYTES);
	localparam logic [15:0] HW_ETHERNET      = 16'h0001;
	localparam logic [15:0] PROTO_IPV4       = 16'h0800;
	localparam logic [15:0] ETHERTYPE_ARP    = 16'h0806;
	localparam logic [7:0]  HW_LEN_ETHERNET  = 8'd6;
	localparam logic [7:0]  PROTO_LEN_IPV4   = 8'd4;
	localparam logic [15:0] OP_REQUEST       = 16'd1;
	localparam logic [15:0] OP_REPLY         = 16'd2;

	// Commands.
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_FRAME  = 1'b1;

	// Configuration register indexes.
	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

	// Frame status codes.
	typedef logic [2:0] frame_status_t;
	localparam frame_status_t STATUS_LOOKUP        = 3'd0;
	localparam frame_status_t STATUS_DROPPED       = 3'd1;
	localparam frame_status_t STATUS_REPLY_LEARNED = 3'd2;
	localparam frame_status_t STATUS_REQ_LEARNED   = 3'd3;
	localparam frame_status_t STATUS_REPLY_DUE     = 3'd4;

	// Search token that travels down the row of cache cells.
	typedef struct packed {
		logic        active;
		logic        learn;
		logic [31:0] key;
		logic [47:0] mac;
		logic        found;
		logic        placed;
		logic [47:0] hit_mac;
	} token_t;

endpackage

// ===== rtl/core/arp_responder_with_cache.sv =====
// ARP cache and responder for IPv4 over Ethernet.
//
// A command is accepted at a rising edge where start is high and busy is
// low. Command 0 looks query_ip up in the cache; command 1 presents the
// parsed fields of a received ARP frame, which is checked and, if it is a
// valid request or reply, teaches the cache the sender's address. A request
// aimed at own_ip also reports the addressing of the reply to send.
// Each transaction gives exactly one result, shown on the result ports for
// a single cycle while done is high. The receiver cannot stall, so results
// are never held.
// The cache is a row of CACHE_ENTRIES cells. A search token enters the
// first cell in the accept cycle and moves one cell per clock through the
// register of each cell; busy stays high until the token leaves the last
// cell and falls as done rises, so the next command can be taken while the
// result is shown. A new command is not taken before the last one is through.
// Configuration writes (own_ip at index 0, own_mac at index 1) take effect
// at the edge where cfg_we is high. Reset empties the cache and clears
// own_ip; own_mac appears in no result and is not stored.
module arp_responder_with_cache #(
	parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data,
	// Command channel.
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] query_ip,
	input  logic [10:0] frame_length,
	input  logic [15:0] hardware_type,
	input  logic [15:0] protocol_type,
	input  logic [7:0]  hw_length,
	input  logic [7:0]  proto_length,
	input  logic [15:0] operation,
	input  logic [47:0] src_mac,
	input  logic [31:0] src_ip,
	input  logic [31:0] target_ip,
	// Result channel.
	output logic        done,
	output logic        lookup_hit,
	output logic [47:0] found_mac,
	output logic [2:0]  frame_status,
	output logic        insert_dropped,
	output logic        reply_valid,
	output logic [47:0] reply_target_mac,
	output logic [31:0] reply_target_ip
);

	logic [31:0]             own_ip_q;
	logic                    busy_q;
	logic                    done_q;
	logic                    accept;
	logic                    frame_ok;
	logic                    is_request;
	logic                    is_reply;
	logic                    reply_due;
	arpc_pkg::frame_status_t status_in;
	arpc_pkg::token_t        tok_launch;
	arpc_pkg::token_t        chain [CACHE_ENTRIES+1];
	arpc_pkg::token_t        tok_exit;

	// Transaction context, held while the token travels.
	logic                    cmd_q;
	arpc_pkg::frame_status_t status_q;
	logic                    rvalid_q;
	logic [47:0]             rmac_q;
	logic [31:0]             rip_q;

	// Result registers.
	logic                    hit_q;
	logic [47:0]             fmac_q;
	arpc_pkg::frame_status_t fstat_q;
	logic                    dropped_q;
	logic                    out_rvalid_q;
	logic [47:0]             out_rmac_q;
	logic [31:0]             out_rip_q;

	assign accept = start && !busy_q;

	// Header checks for a received frame.
	assign frame_ok = (frame_length >= arpc_pkg::MIN_FRAME_BYTES) &&
		(hardware_type == arpc_pkg::HW_ETHERNET) &&
		(protocol_type == arpc_pkg::PROTO_IPV4) &&
		(hw_length == arpc_pkg::HW_LEN_ETHERNET) &&
		(proto_length == arpc_pkg::PROTO_LEN_IPV4);
	assign is_request = frame_ok && (operation == arpc_pkg::OP_REQUEST);
	assign is_reply   = frame_ok && (operation == arpc_pkg::OP_REPLY);
	assign reply_due  = is_request && (target_ip == own_ip_q);

	always_comb begin
		if (command == arpc_pkg::CMD_LOOKUP) begin
			status_in = arpc_pkg::STATUS_LOOKUP;
		end else if (is_reply) begin
			status_in = arpc_pkg::STATUS_REPLY_LEARNED;
		end else if (reply_due) begin
			status_in = arpc_pkg::STATUS_REPLY_DUE;
		end else if (is_request) begin
			status_in = arpc_pkg::STATUS_REQ_LEARNED;
		end else begin
			status_in = arpc_pkg::STATUS_DROPPED;
		end
	end

	// Launch token. A sender address of zero is never learned.
	always_comb begin
		tok_launch.active  = accept;
		tok_launch.learn   = (command == arpc_pkg::CMD_FRAME) && (is_request || is_reply) &&
			(src_ip != '0);
		tok_launch.key     = (command == arpc_pkg::CMD_LOOKUP) ? query_ip : src_ip;
		tok_launch.mac     = src_mac;
		tok_launch.found   = 1'b0;
		tok_launch.placed  = 1'b0;
		tok_launch.hit_mac = '0;
	end

	assign chain[0] = tok_launch;

	for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
		arpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1])
		);
	end

	assign tok_exit = chain[CACHE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == arpc_pkg::REG_OWN_IP)) begin
				own_ip_q <= cfg_data[31:0];
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tok_exit.active) begin
				busy_q <= 1'b0;
			end
			done_q <= tok_exit.active;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			status_q <= status_in;
			rvalid_q <= (command == arpc_pkg::CMD_FRAME) && reply_due;
			rmac_q   <= src_mac;
			rip_q    <= src_ip;
		end
		if (tok_exit.active) begin
			// A learning frame that neither matched nor found a free cell hit
			// a full table.
			hit_q        <= (cmd_q == arpc_pkg::CMD_LOOKUP) && tok_exit.found;
			fmac_q       <= ((cmd_q == arpc_pkg::CMD_LOOKUP) && tok_exit.found) ?
				tok_exit.hit_mac : '0;
			fstat_q      <= status_q;
			dropped_q    <= tok_exit.learn && !tok_exit.found && !tok_exit.placed;
			out_rvalid_q <= rvalid_q;
			out_rmac_q   <= rvalid_q ? rmac_q : '0;
			out_rip_q    <= rvalid_q ? rip_q : '0;
		end
	end

	assign busy             = busy_q;
	assign done             = done_q;
	assign lookup_hit       = hit_q;
	assign found_mac        = fmac_q;
	assign frame_status     = fstat_q;
	assign insert_dropped   = dropped_q;
	assign reply_valid      = out_rvalid_q;
	assign reply_target_mac = out_rmac_q;
	assign reply_target_ip  = out_rip_q;

	// A result always ends the transaction.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while still busy");

	// An accepted command keeps the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted command did not raise busy");

	// A full-table drop only comes from a learning frame.
	a_drop_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && insert_dropped) |-> (frame_status == arpc_pkg::STATUS_REPLY_LEARNED ||
		frame_status == arpc_pkg::STATUS_REQ_LEARNED ||
		frame_status == arpc_pkg::STATUS_REPLY_DUE))
		else $error("insert drop on a non-learning transaction");

	// A reply is due exactly when the status says so.
	a_reply_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (reply_valid == (frame_status == arpc_pkg::STATUS_REPLY_DUE)))
		else $error("reply flag disagrees with status");

	// A hit is only reported for a lookup.
	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(done && lookup_hit) |-> (frame_status == arpc_pkg::STATUS_LOOKUP))
		else $error("hit reported for a frame");

endmodule

// ===== rtl/core/arpc_cell.sv =====
// One cache entry. A token passing through compares against the entry,
// refreshes it on a learned match, or claims it if it is the first free slot.
module arpc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  arpc_pkg::token_t  tok_in,
	output arpc_pkg::token_t  tok_out
);

	logic             valid_q;
	logic [31:0]      ip_q;
	logic [47:0]      mac_q;
	logic             active_q;
	logic             learn_q;
	logic [31:0]      key_q;
	logic [47:0]      tmac_q;
	logic             found_q;
	logic             placed_q;
	logic [47:0]      hit_mac_q;
	logic             match;
	logic             claim;

	// Slots fill in order, so the first free cell a token meets means the
	// key is in none of the cells after it either.
	assign match = tok_in.active && valid_q && (ip_q == tok_in.key) &&
		(tok_in.key != '0) && !tok_in.found;
	assign claim = tok_in.active && !valid_q && tok_in.learn &&
		!tok_in.found && !tok_in.placed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			active_q <= 1'b0;
		end else begin
			active_q <= tok_in.active;
			if (claim) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		learn_q   <= tok_in.learn;
		key_q     <= tok_in.key;
		tmac_q    <= tok_in.mac;
		found_q   <= tok_in.found || match;
		placed_q  <= tok_in.placed || claim;
		hit_mac_q <= match ? mac_q : tok_in.hit_mac;
		if (claim) begin
			ip_q  <= tok_in.key;
			mac_q <= tok_in.mac;
		end else if (match && tok_in.learn) begin
			mac_q <= tok_in.mac;
		end
	end

	assign tok_out = '{active: active_q, learn: learn_q, key: key_q, mac: tmac_q,
		found: found_q, placed: placed_q, hit_mac: hit_mac_q};

endmodule
